>>> hw/rtl/sbas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbas_pkg;

    localparam int MAX_DIGITS = 16;
    localparam int NIBBLE_W   = 4;
    localparam int WORD_W     = MAX_DIGITS * NIBBLE_W;
    localparam int LEN_W      = 5;
    localparam int OP_W       = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
    localparam logic [OP_W-1:0] OP_TENS  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL10 = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV10 = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic              a_sign;
        logic [WORD_W-1:0] a_digits;
        logic              b_sign;
        logic [WORD_W-1:0] b_digits;
    } in_word_t;

    typedef struct packed {
        logic              result_sign;
        logic [WORD_W-1:0] result_digits;
        logic [LEN_W-1:0]  result_length;
        logic              overflow;
    } out_word_t;

    // significant digit count, at least one
    function automatic logic [LEN_W-1:0] sig_len(input logic [WORD_W-1:0] d);
        logic [LEN_W-1:0] len;
        len = LEN_W'(1);
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (d[NIBBLE_W*i +: NIBBLE_W] != '0)
            begin
                len = LEN_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sbas_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbas_in_if;

    logic               valid;
    logic               ready;
    sbas_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> hw/rtl/sbas_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbas_out_if;

    logic                valid;
    logic                ready;
    sbas_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> hw/rtl/sbas_dec_adder.sv
`timescale 1ns / 1ps
`default_nettype none

// Decimal adder, one binary add: each digit is biased by six so that the
// binary nibble carry is the decimal carry; nibbles without carry drop the bias.
module sbas_dec_adder #(
    parameter int DIGITS = 16
) (
    input  wire logic [sbas_pkg::WORD_W-1:0] x,
    input  wire logic [sbas_pkg::WORD_W-1:0] y,
    input  wire logic                        cin,
    output logic      [sbas_pkg::WORD_W-1:0] sum,
    output logic                             cout
);
    import sbas_pkg::*;

    localparam int W = NIBBLE_W * DIGITS;
    localparam logic [W-1:0] SIX = {DIGITS{4'h6}};

    logic [W:0] wide;
    logic [W:0] cv;

    assign wide = {1'b0, x[W-1:0]} + {1'b0, y[W-1:0]} + {1'b0, SIX} + {{W{1'b0}}, cin};
    assign cv   = wide ^ {1'b0, x[W-1:0]} ^ {1'b0, y[W-1:0]} ^ {1'b0, SIX};
    assign cout = wide[W];

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (cv[NIBBLE_W*(i+1)])
            begin
                sum[NIBBLE_W*i +: NIBBLE_W] = wide[NIBBLE_W*i +: NIBBLE_W];
            end
            else
            begin
                sum[NIBBLE_W*i +: NIBBLE_W] = wide[NIBBLE_W*i +: NIBBLE_W] - 4'd6;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sbas_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Combinational datapath: operand clean-up, three decimal adders side by
// side, operation select, sign and length fix-up.
module sbas_alu #(
    parameter int DIGITS = 16
) (
    input  wire sbas_pkg::in_word_t  op_word,
    output sbas_pkg::out_word_t      res_word
);
    import sbas_pkg::*;

    localparam int W = NIBBLE_W * DIGITS;
    localparam logic [WORD_W-1:0] DIG_MASK = {WORD_W{1'b1}} >> (WORD_W - W);

    logic [WORD_W-1:0] a_d;
    logic [WORD_W-1:0] b_d;
    logic [WORD_W-1:0] a_9c;
    logic [WORD_W-1:0] b_9c;
    logic [WORD_W-1:0] b_op;
    logic              a_nz;
    logic              b_nz;
    logic              a_s;
    logic              b_s;
    logic              b_eff;

    logic [WORD_W-1:0] sum_ab;
    logic              carry_ab;
    logic [WORD_W-1:0] diff_ab;
    logic              a_ge_b;
    logic [WORD_W-1:0] diff_ba;
    logic [LEN_W-1:0]  a_len;
    logic [WORD_W-1:0] tens_d;

    logic [WORD_W-1:0] r_d;
    logic              r_s;
    logic              r_ovf;
    logic              len_fixed;

    // clamp non-decimal digits to nine, drop digits above DIGITS
    always_comb
    begin
        logic [NIBBLE_W-1:0] na;
        logic [NIBBLE_W-1:0] nb;
        a_d  = '0;
        b_d  = '0;
        a_9c = '0;
        b_9c = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            na = op_word.a_digits[NIBBLE_W*i +: NIBBLE_W];
            nb = op_word.b_digits[NIBBLE_W*i +: NIBBLE_W];
            if (na > 4'd9) na = 4'd9;
            if (nb > 4'd9) nb = 4'd9;
            a_d[NIBBLE_W*i +: NIBBLE_W]  = na;
            b_d[NIBBLE_W*i +: NIBBLE_W]  = nb;
            a_9c[NIBBLE_W*i +: NIBBLE_W] = 4'd9 - na;
            b_9c[NIBBLE_W*i +: NIBBLE_W] = 4'd9 - nb;
        end
    end

    assign a_nz  = |a_d;
    assign b_nz  = |b_d;
    assign a_s   = op_word.a_sign & a_nz;
    assign b_s   = op_word.b_sign & b_nz;
    assign b_eff = (op_word.operation == OP_SUB) ? (b_s ^ b_nz) : b_s;
    // ten's complement of a is 0 - a through the b - a adder
    assign b_op  = (op_word.operation == OP_TENS) ? '0 : b_d;

    sbas_dec_adder #(.DIGITS(DIGITS)) u_add_ab (
        .x    (a_d),
        .y    (b_d),
        .cin  (1'b0),
        .sum  (sum_ab),
        .cout (carry_ab)
    );

    sbas_dec_adder #(.DIGITS(DIGITS)) u_sub_ab (
        .x    (a_d),
        .y    (b_9c),
        .cin  (1'b1),
        .sum  (diff_ab),
        .cout (a_ge_b)
    );

    sbas_dec_adder #(.DIGITS(DIGITS)) u_sub_ba (
        .x    (b_op),
        .y    (a_9c),
        .cin  (1'b1),
        .sum  (diff_ba),
        .cout ()
    );

    assign a_len = sig_len(a_d);

    // keep only the digits up to the length of a
    always_comb
    begin
        tens_d = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (LEN_W'(i) < a_len)
            begin
                tens_d[NIBBLE_W*i +: NIBBLE_W] = diff_ba[NIBBLE_W*i +: NIBBLE_W];
            end
        end
    end

    always_comb
    begin
        r_d       = '0;
        r_s       = 1'b0;
        r_ovf     = 1'b0;
        len_fixed = 1'b0;
        unique case (op_word.operation)
            OP_ADD, OP_SUB:
            begin
                if (a_s == b_eff)
                begin
                    r_d   = sum_ab;
                    r_ovf = carry_ab;
                    r_s   = a_s;
                end
                else if (a_ge_b)
                begin
                    r_d = diff_ab;
                    r_s = a_s;
                end
                else
                begin
                    r_d = diff_ba;
                    r_s = b_eff;
                end
            end
            OP_TENS:
            begin
                if (a_s)
                begin
                    r_d       = tens_d;
                    r_s       = 1'b1;
                    len_fixed = 1'b1;
                end
                else
                begin
                    r_d = a_d;
                end
            end
            OP_MUL10:
            begin
                r_d   = (a_d << NIBBLE_W) & DIG_MASK;
                r_ovf = |a_d[W-1 -: NIBBLE_W];
                r_s   = a_s;
            end
            OP_DIV10:
            begin
                r_d = a_d >> NIBBLE_W;
                r_s = a_s;
            end
            default:
            begin
                r_d = '0;
            end
        endcase
    end

    always_comb
    begin
        res_word.result_digits = r_d;
        res_word.overflow      = r_ovf;
        if (len_fixed)
        begin
            res_word.result_sign   = 1'b1;
            res_word.result_length = a_len;
        end
        else
        begin
            res_word.result_sign   = r_s & (|r_d);
            res_word.result_length = sig_len(r_d);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/signed_bcd_add_sub_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed packed-BCD ALU on sign-magnitude numbers of DIGITS digits (2..16),
// least significant digit in the low nibble. Operations: add, subtract, ten's
// complement of a, a times ten and a divided by ten (truncating). Nibbles of
// value 10..15 count as 9, nibbles above DIGITS are ignored on input and zero
// on output, and a zero result is always positive with length 1. Overflow
// marks a like-sign add that carries out of the top digit, or a times ten
// whose top digit is nonzero; the digits are then the wrapped value. A word
// is accepted every cycle while the result side does not stall; each word
// passes the operand register and then the result register, and the
// throughput is set by the single-pass datapath between those two
// registers (three decimal adders working in parallel, then select and
// length detect). Both stages hold their word while the result side stalls,
// so one new operand word is still taken while a finished result waits.
module signed_bcd_add_sub_unit #(
    parameter int DIGITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sbas_in_if.sink     operands,
    sbas_out_if.source  results
);
    import sbas_pkg::*;

    localparam int W = NIBBLE_W * DIGITS;
    localparam logic [WORD_W-1:0] DIG_MASK = {WORD_W{1'b1}} >> (WORD_W - W);

    // operand stage
    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_word_t  s1_word_reg;
    logic      s1_ready;

    // result stage
    logic      s2_valid_reg;
    logic      s2_valid_next;
    out_word_t s2_word_reg;
    out_word_t s2_word_next;
    logic      s2_ready;

    // a stage takes a word when empty or when its own word leaves this cycle
    assign s2_ready = !s2_valid_reg || results.ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign operands.ready = s1_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = operands.valid;
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s1_ready && operands.valid)
        begin
            s1_word_reg <= operands.data;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_word_reg <= s2_word_next;
        end
    end

    sbas_alu #(.DIGITS(DIGITS)) u_alu (
        .op_word  (s1_word_reg),
        .res_word (s2_word_next)
    );

    assign results.valid = s2_valid_reg;
    assign results.data  = s2_word_reg;

    // a held operand word is not lost while the result stage is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg)
        else $error("operand word dropped during stall");

    // an accepted operand word lands in the operand register
    a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
        operands.valid && operands.ready |=> s1_valid_reg)
        else $error("accepted operand word not registered");

    // zero is positive with length one
    a_zero_form: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.result_digits == '0
        |-> !results.data.result_sign && results.data.result_length == LEN_W'(1))
        else $error("zero result not in canonical form");

    // digits above DIGITS stay clear
    a_upper_clear: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.data.result_digits & ~DIG_MASK) == '0)
        else $error("result digits above DIGITS not zero");

    // length within 1..DIGITS
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.data.result_length != '0
                       && results.data.result_length <= LEN_W'(DIGITS))
        else $error("result length out of range");

endmodule

`default_nettype wire
